[src/swps_pkg.sv]
// Shared types and constants for the sliding-window percentile statistics block.
`timescale 1ns / 1ps

package swps_pkg;

  // Sample and statistic width, and the fixed width of the reported count.
  localparam int DATA_W     = 16;
  localparam int CNT_OUT_W  = 9;
  localparam int DEF_WINDOW = 256;

  // Percentile points, in percent.
  localparam int NUM_PCT = 3;
  localparam logic [6:0] PCT_Q [NUM_PCT] = '{7'd50, 7'd95, 7'd99};

  // floor(x / 100) = (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 493447,
  // which covers count * 99 for every window up to 4096 samples.
  localparam int PCT_RECIP_W = 19;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 19'd335545;
  localparam int PCT_SHIFT = 25;

  // Operation broadcast to every cell of the sorted row.
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_NOP    = 2'd0;
  localparam cell_op_t OP_REMOVE = 2'd1;
  localparam cell_op_t OP_INSERT = 2'd2;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   key;
  } cell_cmd_t;

endpackage

[src/swps_in_if.sv]
// Input channel: one beat carries a mode bit and a latency sample.
`timescale 1ns / 1ps

interface swps_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] latency_sample;

  modport source (output valid, mode, latency_sample, input ready);
  modport sink   (input valid, mode, latency_sample, output ready);
endinterface

[src/swps_out_if.sv]
// Result channel: one beat carries the window statistics after an item.
`timescale 1ns / 1ps

interface swps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] median_value;
  logic [15:0] pct95_value;
  logic [15:0] pct99_value;
  logic [15:0] mean_value;
  logic [8:0]  sample_count;

  modport source (output valid, median_value, pct95_value, pct99_value, mean_value,
                  sample_count, input ready);
  modport sink   (input valid, median_value, pct95_value, pct99_value, mean_value,
                  sample_count, output ready);
endinterface

[src/swps_cell.sv]
// One cell of the sorted sample row; shifts with its neighbors on remove and insert.
`timescale 1ns / 1ps

module swps_cell
  import swps_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CNT_W-1:0]  count,
  input  logic [DATA_W-1:0] left_val,
  input  logic              left_gt,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val_out,
  output logic              gt_out
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              valid;

  // The cell holds a sample when its position is below the fill count.
  assign valid   = count > CNT_W'(IDX);
  assign gt_out  = valid && (val_r > cmd.key);
  assign val_out = val_r;

  // Remove: every cell at or above the first copy of the key takes its right
  // neighbor. Insert: cells above the key take their left neighbor, and the
  // first cell not taking it receives the key.
  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      OP_REMOVE: begin
        if (val_r >= cmd.key) val_nxt = right_val;
      end
      OP_INSERT: begin
        if (left_gt) begin
          val_nxt = left_val;
        end else if (!valid || (val_r > cmd.key)) begin
          val_nxt = cmd.key;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[src/swps_div.sv]
// Radix-2 restoring divider for the window mean, one quotient bit per cycle.
`timescale 1ns / 1ps

module swps_div
  import swps_pkg::*;
#(
  parameter int CNT_W = 9,
  parameter int SUM_W = DATA_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W + 1);

  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [DATA_W-1:0] lo_r;
  logic [DATA_W-1:0] lo_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // The sum never exceeds count * 65535, so the upper part of the dividend
  // is already below the divisor and sixteen steps give the whole quotient.
  assign trial = {rem_r, lo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    lo_nxt  = {lo_r[DATA_W-2:0], ge};
  end

  // Control: load on start, then count down the quotient bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(DATA_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) busy_r <= 1'b0;
    end
  end

  // Datapath: partial remainder and dividend bits that turn into the quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[SUM_W-1:DATA_W];
      lo_r  <= dividend[DATA_W-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = lo_r;

endmodule

[src/sliding_window_percentile_stats.sv]
// Top level: sliding-window latency percentiles, mean and sample count.
//
// The block keeps the last WINDOW latency samples, both in arrival order
// (a ring memory) and in ascending order (a row of shifting cells).
// Input beats on in_ch carry mode and latency_sample: mode 0 records the
// sample and evicts the oldest one once the window is full, mode 1 empties
// the window. Each input beat yields exactly one beat on out_ch with the
// median, the 95th and 99th percentiles, the floor of the mean and the
// sample count; all fields are zero for an empty window.
// One item is processed at a time: an evicting record first reads the oldest
// sample and removes it from the row, a record inserts the new sample, and
// then the percentile index and mean division run; in_ch.ready rises with
// out_ch.valid, so a new item can be taken on the edge that takes the result.
// A result that the receiver does not take stays in the output register;
// the next input beat is still accepted, and its result waits until the
// earlier one has been taken. Reset empties the window and drops any
// pending result; no clearing pass over the stores is needed.
`timescale 1ns / 1ps

module sliding_window_percentile_stats
  import swps_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic       clk,
  input  logic       rst_n,
  swps_in_if.sink    in_ch,
  swps_out_if.source out_ch
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int PQ_W  = CNT_W + 7;
  localparam int PR_W  = PQ_W + PCT_RECIP_W;
  localparam int GRP   = 16;
  localparam int NGRP  = (WINDOW + GRP - 1) / GRP;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_REMOVE = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_MULQ   = 3'd4;
  localparam logic [2:0] S_MULR   = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [DATA_W-1:0] sample_r;
  logic [IDX_W-1:0]  head_r;
  logic [IDX_W-1:0]  head_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic              in_beat;
  logic              out_beat;
  logic              full;
  logic              out_load;

  // Arrival-order ring.
  logic [DATA_W-1:0] ring_mem [WINDOW];
  logic [DATA_W-1:0] ring_rd_r;
  logic              ring_we;
  logic [CNT_W:0]    wsum;
  logic [CNT_W:0]    wwrap;
  logic [IDX_W-1:0]  ring_waddr;

  // Sorted cell row.
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_val [WINDOW];
  logic              cell_gt  [WINDOW];

  // Percentile index and readout pipeline.
  logic [PQ_W-1:0]   prodq_r  [NUM_PCT];
  logic [PR_W-1:0]   prodr_r  [NUM_PCT];
  logic [IDX_W-1:0]  idx_r    [NUM_PCT];
  logic [IDX_W-1:0]  idx_nxt  [NUM_PCT];
  logic [DATA_W-1:0] grp_r    [NUM_PCT][NGRP];
  logic [DATA_W-1:0] grp_nxt  [NUM_PCT][NGRP];
  logic [DATA_W-1:0] pick_r   [NUM_PCT];
  logic [DATA_W-1:0] pick_nxt [NUM_PCT];

  // Mean divider.
  logic              div_start;
  logic              div_busy;
  logic [DATA_W-1:0] div_quo;

  // Output register.
  logic              out_valid_r;
  logic [DATA_W-1:0] median_r;
  logic [DATA_W-1:0] pct95_r;
  logic [DATA_W-1:0] pct99_r;
  logic [DATA_W-1:0] mean_r;
  logic [CNT_OUT_W-1:0] cnt_out_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_beat    = out_valid_r && out_ch.ready;
  assign full        = (count_r == CNT_W'(WINDOW));
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign div_start   = (state_r == S_MULQ);
  assign ring_we     = (state_r == S_INSERT);

  // Sequencer and window bookkeeping.
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    cmd.op    = OP_NOP;
    cmd.key   = sample_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_ch.mode) begin
            head_nxt  = '0;
            count_nxt = '0;
            sum_nxt   = '0;
            state_nxt = S_MULQ;
          end else begin
            state_nxt = full ? S_READ : S_INSERT;
          end
        end
      end
      S_READ: state_nxt = S_REMOVE;
      S_REMOVE: begin
        cmd.op    = OP_REMOVE;
        cmd.key   = ring_rd_r;
        sum_nxt   = sum_r - SUM_W'(ring_rd_r);
        count_nxt = count_r - 1'b1;
        head_nxt  = (head_r == IDX_W'(WINDOW - 1)) ? '0 : head_r + 1'b1;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.op    = OP_INSERT;
        sum_nxt   = sum_r + SUM_W'(sample_r);
        count_nxt = count_r + 1'b1;
        state_nxt = S_MULQ;
      end
      S_MULQ: state_nxt = S_MULR;
      S_MULR: state_nxt = S_DIV;
      S_DIV: begin
        if (!div_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) sample_r <= in_ch.latency_sample;
  end

  // Ring write slot is the one just past the newest sample.
  always_comb begin
    wsum  = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(count_r);
    wwrap = (wsum >= (CNT_W + 1)'(WINDOW)) ? wsum - (CNT_W + 1)'(WINDOW) : wsum;
    ring_waddr = wwrap[IDX_W-1:0];
  end

  // Ring memory: one write port, one registered read of the oldest slot.
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= sample_r;
    ring_rd_r <= ring_mem[head_r];
  end

  // Sorted cell row.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [DATA_W-1:0] lv;
    logic              lg;
    logic [DATA_W-1:0] rv;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_inner_l
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner_r
      assign rv = cell_val[i+1];
    end
    swps_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val_out   (cell_val[i]),
      .gt_out    (cell_gt[i])
    );
  end

  // Percentile index: count * q, then a reciprocal multiply for the /100.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_PCT; k++) begin
      if (state_r == S_MULQ) prodq_r[k] <= PQ_W'(count_r) * PQ_W'(PCT_Q[k]);
      if (state_r == S_MULR) prodr_r[k] <= PR_W'(prodq_r[k]) * PR_W'(PCT_RECIP);
    end
  end

  // Clamp the index to the last held sample.
  always_comb begin
    for (int k = 0; k < NUM_PCT; k++) begin
      if (prodr_r[k][PR_W-1:PCT_SHIFT] >= {1'b0, count_r}) begin
        idx_nxt[k] = IDX_W'(count_r - 1'b1);
      end else begin
        idx_nxt[k] = IDX_W'(prodr_r[k][PR_W-1:PCT_SHIFT]);
      end
    end
  end

  // Readout: select within groups of sixteen cells, then across groups.
  always_comb begin
    for (int k = 0; k < NUM_PCT; k++) begin
      for (int g = 0; g < NGRP; g++) grp_nxt[k][g] = '0;
    end
    for (int i = 0; i < WINDOW; i++) begin
      for (int k = 0; k < NUM_PCT; k++) begin
        if (idx_r[k] == IDX_W'(i)) grp_nxt[k][i / GRP] = grp_nxt[k][i / GRP] | cell_val[i];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PCT; k++) begin
      pick_nxt[k] = '0;
      for (int g = 0; g < NGRP; g++) pick_nxt[k] = pick_nxt[k] | grp_r[k][g];
    end
  end

  // The readout pipeline runs freely and settles while the divider works.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    grp_r  <= grp_nxt;
    pick_r <= pick_nxt;
  end

  swps_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Output register; an empty window reports all zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_beat) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (count_r == '0) begin
        median_r  <= '0;
        pct95_r   <= '0;
        pct99_r   <= '0;
        mean_r    <= '0;
        cnt_out_r <= '0;
      end else begin
        median_r  <= pick_r[0];
        pct95_r   <= pick_r[1];
        pct99_r   <= pick_r[2];
        mean_r    <= div_quo;
        cnt_out_r <= CNT_OUT_W'(count_r);
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.median_value = median_r;
  assign out_ch.pct95_value  = pct95_r;
  assign out_ch.pct99_value  = pct99_r;
  assign out_ch.mean_value   = mean_r;
  assign out_ch.sample_count = cnt_out_r;

  // The window never holds more than WINDOW samples.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW))
    else $error("fill count above window size");

  // A clear beat empties the window on the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_ch.mode) |=> (count_r == '0) && (sum_r == '0))
    else $error("clear did not empty the window");

  // Each insert adds exactly one sample.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the window by one");

  // A result is never formed before the mean division has finished.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> !div_busy)
    else $error("result formed while divider busy");

  // A waiting result is not overwritten by the next item.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_valid_r && !out_ch.ready) |=> (state_r == S_OUT))
    else $error("pending result overwritten");

endmodule
